// File: hdl/gbfs_pkg.sv
// Shared types and constants for the greedy best-first search block.
`default_nettype none

package gbfs_pkg;

  localparam int NODE_W = 6;
  localparam int VAL_W = 16;
  localparam int CFG_W = 7;
  localparam int OUT_MAX = 64;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    MODE_HEUR   = 2'd0,
    MODE_EDGE   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_SEARCH = 2'd3
  } gbfs_mode_e;

  typedef enum logic [3:0] {
    ST_SWEEP_ALL,
    ST_SWEEP_ADJ,
    ST_IDLE,
    ST_EDGE_WR,
    ST_SCAN,
    ST_EXP_RD,
    ST_EXP_UP,
    ST_TR_WR,
    ST_TR_RD,
    ST_EM_RD,
    ST_EM_OUT,
    ST_FAIL
  } gbfs_state_e;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic sweep_heur;
    logic edge_wr;
    logic scan;
    logic exp_rd;
    logic exp_up;
    logic tr_wr;
    logic tr_rd;
    logic em_rd;
    logic em_next;
    logic show_path;
  } gbfs_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic ends_ok;
    logic scan_done;
    logic have;
    logic best_is_goal;
    logic at_start;
    logic emit_last;
  } gbfs_sts_t;

endpackage

`default_nettype wire

// File: hdl/gbfs_ctrl.sv
// Controller state machine sequencing loads, clears, the search and the path output.
`default_nettype none

module gbfs_ctrl
  import gbfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] mode_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire gbfs_sts_t  sts_i,
  output gbfs_cmd_t       cmd_o
);

  gbfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP_ALL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_SWEEP_ALL, ST_SWEEP_ADJ: begin
        cmd_o.sweep = 1'b1;
        cmd_o.sweep_heur = (state_q == ST_SWEEP_ALL);
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (gbfs_mode_e'(mode_i))
            MODE_HEUR:   state_d = ST_IDLE;
            MODE_EDGE:   state_d = ST_EDGE_WR;
            MODE_CLEAR:  state_d = ST_SWEEP_ADJ;
            MODE_SEARCH: state_d = sts_i.ends_ok ? ST_SCAN : ST_FAIL;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_WR: begin
        cmd_o.edge_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          priority if (!sts_i.have) begin
            state_d = ST_FAIL;
          end else if (sts_i.best_is_goal) begin
            state_d = ST_TR_WR;
          end else begin
            state_d = ST_EXP_RD;
          end
        end
      end
      ST_EXP_RD: begin
        cmd_o.exp_rd = 1'b1;
        state_d = ST_EXP_UP;
      end
      ST_EXP_UP: begin
        cmd_o.exp_up = 1'b1;
        state_d = ST_SCAN;
      end
      ST_TR_WR: begin
        cmd_o.tr_wr = 1'b1;
        state_d = sts_i.at_start ? ST_EM_RD : ST_TR_RD;
      end
      ST_TR_RD: begin
        cmd_o.tr_rd = 1'b1;
        state_d = ST_TR_WR;
      end
      ST_EM_RD: begin
        cmd_o.em_rd = 1'b1;
        state_d = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        cmd_o.show_path = 1'b1;
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.em_next = 1'b1;
            state_d = ST_EM_RD;
          end
        end
      end
      ST_FAIL: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/gbfs_dp.sv
// Datapath with the graph memories, node sets, frontier scan, path trace and output word.
`default_nettype none

module gbfs_dp
  import gbfs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int HEUR_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic [NODE_W-1:0] node_i,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic [NODE_W-1:0] start_node_i,
  input  wire logic [NODE_W-1:0] goal_node_i,
  input  wire gbfs_cmd_t         cmd_i,
  output gbfs_sts_t              sts_o,
  output logic [NODE_W-1:0]      path_node_o,
  output logic                   found_o,
  output logic                   last_o
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [HEUR_BITS-1:0] heur_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [IDX_W-1:0]     par_mem [MAX_NODES];
  logic [IDX_W-1:0]     stk_mem [MAX_NODES];

  logic [CFG_W-1:0]     node_count_q;
  logic [CNT_W-1:0]     cnt;
  logic [MAX_NODES-1:0] mask;
  logic [IDX_W-1:0]     node_idx, start_idx, goal_idx;
  logic                 node_ok, dst_ok;
  logic                 acc_heur, acc_edge, acc_search;

  logic [IDX_W-1:0]     sweep_idx_q;
  logic [IDX_W-1:0]     edge_src_q, edge_dst_q;
  logic                 edge_ok_q;
  logic [MAX_NODES-1:0] adj_q;
  logic [HEUR_BITS-1:0] heur_q;
  logic [IDX_W-1:0]     par_q;
  logic [IDX_W-1:0]     stk_q;

  logic [MAX_NODES-1:0] visited_q, frontier_q, new_q, fresh;
  logic [IDX_W-1:0]     start_q, goal_q, best_q, par_src_q, cur_q, ptr_q;
  logic [CNT_W-1:0]     scan_idx_q, len_q;
  logic [IDX_W-1:0]     pidx_q;
  logic                 pv_q, have_q;
  logic [HEUR_BITS-1:0] bh_q;
  logic [CFG_W-1:0]     rem_q;
  logic                 scan_issue;
  logic [31:0]          len_next;

  assign cnt = (32'(node_count_q) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_q);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      mask[i] = (32'(i) < 32'(cnt));
    end
  end

  assign node_idx   = IDX_W'(node_i);
  assign start_idx  = IDX_W'(start_node_i);
  assign goal_idx   = IDX_W'(goal_node_i);
  assign node_ok    = (32'(node_i) < MAX_NODES);
  assign dst_ok     = (32'(value_i) < MAX_NODES);
  assign acc_heur   = cmd_i.accept && (gbfs_mode_e'(mode_i) == MODE_HEUR);
  assign acc_edge   = cmd_i.accept && (gbfs_mode_e'(mode_i) == MODE_EDGE);
  assign acc_search = cmd_i.accept && (gbfs_mode_e'(mode_i) == MODE_SEARCH);
  assign scan_issue = cmd_i.scan && (scan_idx_q < cnt);
  assign fresh      = adj_q & ~visited_q & mask;
  assign len_next   = 32'(len_q) + 32'd1;

  assign sts_o.sweep_done   = (sweep_idx_q == IDX_W'(MAX_NODES - 1));
  assign sts_o.ends_ok      = (32'(start_node_i) < 32'(cnt)) && (32'(goal_node_i) < 32'(cnt));
  assign sts_o.scan_done    = (scan_idx_q == cnt) && !pv_q;
  assign sts_o.have         = have_q;
  assign sts_o.best_is_goal = (best_q == goal_q);
  assign sts_o.at_start     = (cur_q == start_q);
  assign sts_o.emit_last    = (rem_q == 7'd1);

  assign path_node_o = cmd_i.show_path ? NODE_W'(stk_q) : '0;
  assign found_o     = cmd_i.show_path;
  assign last_o      = !cmd_i.show_path || (rem_q == 7'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_heur) begin
      heur_mem[sweep_idx_q] <= '0;
    end else if (acc_heur && node_ok) begin
      heur_mem[node_idx] <= HEUR_BITS'(value_i);
    end
    if (scan_issue) begin
      heur_q <= heur_mem[scan_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      adj_mem[sweep_idx_q] <= '0;
    end else if (cmd_i.edge_wr && edge_ok_q) begin
      adj_mem[edge_src_q] <= adj_q | ({{(MAX_NODES-1){1'b0}}, 1'b1} << edge_dst_q);
    end
    if (cmd_i.exp_rd) begin
      adj_q <= adj_mem[best_q];
    end else if (acc_edge) begin
      adj_q <= adj_mem[node_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue && new_q[scan_idx_q[IDX_W-1:0]]) begin
      par_mem[scan_idx_q[IDX_W-1:0]] <= par_src_q;
    end
    if (cmd_i.tr_wr) begin
      par_q <= par_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tr_wr) begin
      stk_mem[len_q[IDX_W-1:0]] <= cur_q;
    end
    if (cmd_i.em_rd) begin
      stk_q <= stk_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_edge) begin
      edge_src_q <= node_idx;
      edge_dst_q <= IDX_W'(value_i);
      edge_ok_q  <= node_ok && dst_ok;
    end
    if (acc_search) begin
      start_q <= start_idx;
      goal_q  <= goal_idx;
    end
    if (cmd_i.exp_up) begin
      par_src_q <= best_q;
    end
    if (pv_q && frontier_q[pidx_q] && (!have_q || heur_q < bh_q)) begin
      best_q <= pidx_q;
      bh_q   <= heur_q;
    end
    if (scan_issue) begin
      pidx_q <= scan_idx_q[IDX_W-1:0];
    end
    if (acc_search) begin
      cur_q <= goal_idx;
    end else if (cmd_i.tr_rd) begin
      cur_q <= par_q;
    end
    if (cmd_i.tr_wr) begin
      ptr_q <= len_q[IDX_W-1:0];
      rem_q <= (len_next > OUT_MAX) ? CFG_W'(OUT_MAX) : CFG_W'(len_next);
    end else if (cmd_i.em_next) begin
      ptr_q <= ptr_q - IDX_W'(1);
      rem_q <= rem_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      sweep_idx_q  <= '0;
      visited_q    <= '0;
      frontier_q   <= '0;
      new_q        <= '0;
      scan_idx_q   <= '0;
      pv_q         <= 1'b0;
      have_q       <= 1'b0;
      len_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.sweep) begin
        sweep_idx_q <= sts_o.sweep_done ? '0 : sweep_idx_q + IDX_W'(1);
      end
      if (acc_search) begin
        visited_q  <= sts_o.ends_ok ? ({{(MAX_NODES-1){1'b0}}, 1'b1} << start_idx) : '0;
        frontier_q <= sts_o.ends_ok ? ({{(MAX_NODES-1){1'b0}}, 1'b1} << start_idx) : '0;
        new_q <= '0;
        len_q <= '0;
      end else if (cmd_i.exp_up) begin
        visited_q  <= visited_q | fresh;
        frontier_q <= (frontier_q | fresh) & ~({{(MAX_NODES-1){1'b0}}, 1'b1} << best_q);
        new_q      <= fresh;
      end else if (cmd_i.tr_wr) begin
        len_q <= CNT_W'(len_next);
      end
      if (acc_search || cmd_i.exp_up) begin
        scan_idx_q <= '0;
        pv_q       <= 1'b0;
        have_q     <= 1'b0;
      end else begin
        if (scan_issue) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
        pv_q <= scan_issue;
        if (pv_q && frontier_q[pidx_q]) begin
          have_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/greedy_best_first_search.sv
// Top level of the greedy best-first search block.
//
// Input words carry an operation: set a node's heuristic, add a directed edge,
// clear all edges, or run a search from start_node_i to goal_node_i. A word is
// taken when in_valid_i is high and in_stall_o is low; results leave when
// out_valid_o is high and out_stall_i is low.
// Clearing the graph sweeps the edge memory one row per cycle. A search runs,
// per expanded node, one scan of the heuristic memory over the nodes in use;
// the scan reads one entry per cycle. The path is then traced back from the
// goal and sent out from start to goal, one word at a time; a failed search
// sends one word with found_o low. After reset the block clears both graph
// memories in one pass and holds in_stall_o high meanwhile. The user must
// write node_count only while no word is in flight; the block does not
// enforce this.
// A stalled output word holds its value until taken; no new input word is
// taken until the last word of a search has left.
`default_nettype none

module greedy_best_first_search
  import gbfs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int HEUR_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [NODE_W-1:0] node_i,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic [NODE_W-1:0] start_node_i,
  input  wire logic [NODE_W-1:0] goal_node_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [NODE_W-1:0]      path_node_o,
  output logic                   found_o,
  output logic                   last_o
);

  gbfs_cmd_t cmd;
  gbfs_sts_t sts;

  gbfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbfs_dp #(
    .MAX_NODES (MAX_NODES),
    .HEUR_BITS (HEUR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .node_i       (node_i),
    .value_i      (value_i),
    .start_node_i (start_node_i),
    .goal_node_i  (goal_node_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .path_node_o  (path_node_o),
    .found_o      (found_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/greedy_best_first_search_test.sv
// Self-checking testbench for the greedy best-first search block.
`timescale 1ns / 1ps

module greedy_best_first_search_test;
  import gbfs_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic              last;
  } path_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        mode_i = '0;
  logic [NODE_W-1:0] node_i = '0;
  logic [VAL_W-1:0]  value_i = '0;
  logic [NODE_W-1:0] start_node_i = '0;
  logic [NODE_W-1:0] goal_node_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [NODE_W-1:0] path_node_o;
  logic              found_o;
  logic              last_o;

  logic [15:0] heur_mem [64];
  logic [63:0] adj_mem [64];
  logic [6:0]  nodes_in_use;
  path_word_t  path_words_q [$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          out_wait = 0;
  bit          no_idle = 1'b0;

  greedy_best_first_search u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .node_i      (node_i),
    .value_i     (value_i),
    .start_node_i(start_node_i),
    .goal_node_i (goal_node_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .path_node_o (path_node_o),
    .found_o     (found_o),
    .last_o      (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void push_word(logic [5:0] n, logic f, logic l);
    path_word_t w;
    w.node = n;
    w.found = f;
    w.last = l;
    path_words_q.insert(path_words_q.size(), w);
  endfunction

  function automatic void predict_search(int start, int goal);
    int cnt;
    int parent [64];
    int trail [64];
    logic [63:0] seen;
    logic [63:0] open_set;
    bit hit;
    bit have;
    int best;
    logic [15:0] best_h;
    int len;
    int cur;
    cnt = (nodes_in_use > 64) ? 64 : int'(nodes_in_use);
    seen = '0;
    open_set = '0;
    hit = 1'b0;
    if (start >= cnt || goal >= cnt) begin
      push_word('0, 1'b0, 1'b1);
      return;
    end
    seen[start] = 1'b1;
    open_set[start] = 1'b1;
    parent[start] = -1;
    for (int step = 0; step <= cnt && !hit; step++) begin
      have = 1'b0;
      best = 0;
      best_h = '0;
      for (int i = 0; i < cnt; i++) begin
        if (open_set[i] && (!have || heur_mem[i] < best_h)) begin
          have = 1'b1;
          best = i;
          best_h = heur_mem[i];
        end
      end
      if (!have) break;
      open_set[best] = 1'b0;
      if (best == goal) begin
        hit = 1'b1;
        break;
      end
      for (int i = 0; i < cnt; i++) begin
        if (adj_mem[best][i] && !seen[i]) begin
          seen[i] = 1'b1;
          parent[i] = best;
          open_set[i] = 1'b1;
        end
      end
    end
    if (!hit) begin
      push_word('0, 1'b0, 1'b1);
      return;
    end
    len = 0;
    cur = goal;
    while (len < 64) begin
      trail[len] = cur;
      len++;
      if (cur == start || parent[cur] < 0) break;
      cur = parent[cur];
    end
    for (int i = 0; i < len; i++) push_word(trail[len-1-i], 1'b1, i + 1 == len);
  endfunction

  function automatic void apply_word(gbfs_mode_e m, logic [5:0] n, logic [15:0] v,
                                     logic [5:0] s, logic [5:0] g);
    case (m)
      MODE_HEUR: heur_mem[n] = v;
      MODE_EDGE: if (v < 64) adj_mem[n][v[5:0]] = 1'b1;
      MODE_CLEAR: for (int i = 0; i < 64; i++) adj_mem[i] = '0;
      default: predict_search(s, g);
    endcase
  endfunction

  task automatic send_word(gbfs_mode_e m, logic [5:0] n, logic [15:0] v,
                           logic [5:0] s, logic [5:0] g);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    node_i <= n;
    value_i <= v;
    start_node_i <= s;
    goal_node_i <= g;
    do @(posedge clk_i); while (in_stall_o);
    apply_word(m, n, v, s, g);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (path_words_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [6:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    nodes_in_use = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_search(logic [5:0] s, logic [5:0] g);
    send_word(MODE_SEARCH, 6'($urandom), 16'($urandom), s, g);
  endtask

  task automatic send_edge(logic [5:0] a, logic [15:0] b);
    send_word(MODE_EDGE, a, b, 6'($urandom), 6'($urandom));
  endtask

  task automatic send_heur(logic [5:0] n, logic [15:0] h);
    send_word(MODE_HEUR, n, h, 6'($urandom), 6'($urandom));
  endtask

  task automatic test_directed();
    send_search(6'd5, 6'd5);
    send_search(6'd0, 6'd63);
    send_heur(6'd0, 16'hFFFF);
    send_heur(6'd63, 16'h0000);
    send_heur(6'd1, 16'h0005);
    send_heur(6'd2, 16'h0005);
    send_edge(6'd0, 16'd1);
    send_edge(6'd0, 16'd2);
    send_edge(6'd1, 16'd63);
    send_edge(6'd2, 16'd63);
    send_edge(6'd63, 16'd64);
    send_edge(6'd63, 16'hFFFF);
    send_search(6'd0, 6'd63);
    send_search(6'd63, 6'd0);
    send_word(MODE_CLEAR, 6'h3F, 16'hFFFF, 6'h3F, 6'h3F);
    send_search(6'd0, 6'd63);
    send_edge(6'd0, 16'd63);
    send_search(6'd0, 6'd63);
  endtask

  task automatic test_node_count();
    write_node_count(7'd0);
    send_search(6'd0, 6'd0);
    write_node_count(7'd1);
    send_search(6'd0, 6'd0);
    send_search(6'd0, 6'd63);
    write_node_count(7'd127);
    send_search(6'd0, 6'd63);
    write_node_count(7'd63);
    send_search(6'd0, 6'd63);
    write_node_count(7'd64);
  endtask

  task automatic test_long_path();
    send_word(MODE_CLEAR, 6'd0, 16'd0, 6'd0, 6'd0);
    for (int i = 0; i < 31; i++) send_edge(6'(i), 16'(i + 1));
    no_idle = 1'b1;
    send_search(6'd0, 6'd31);
    drain();
    no_idle = 1'b0;
  endtask

  task automatic test_random(int cnt, int items);
    int pick;
    int lim;
    lim = (cnt > 64) ? 64 : ((cnt < 1) ? 1 : cnt);
    write_node_count(7'(cnt));
    send_word(MODE_CLEAR, 6'($urandom), 16'($urandom), 6'($urandom), 6'($urandom));
    for (int k = 0; k < items; k++) begin
      if (k % 30 == 15) no_idle = ~no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 25)
        send_heur(6'($urandom_range(0, lim - 1)), 16'($urandom));
      else if (pick < 62)
        send_edge(6'($urandom_range(0, lim - 1)),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, lim)));
      else if (pick < 65)
        send_word(MODE_CLEAR, 6'($urandom), 16'($urandom), 6'($urandom), 6'($urandom));
      else if (pick < 92)
        send_search(6'($urandom_range(0, lim - 1)), 6'($urandom_range(0, lim - 1)));
      else
        send_search(6'($urandom), 6'($urandom));
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    path_word_t exp_w;
    if (out_valid_o && !out_stall_i) begin
      quiet_cycles <= 0;
      if (path_words_q.size() == 0) begin
        $display("%0t: unexpected word node=%0d found=%0b last=%0b",
                 $time, path_node_o, found_o, last_o);
        errors++;
      end else begin
        exp_w = path_words_q.pop_front();
        if (path_node_o !== exp_w.node) begin
          $display("%0t: path_node expected %0d actual %0d", $time, exp_w.node, path_node_o);
          errors++;
        end
        if (found_o !== exp_w.found) begin
          $display("%0t: found expected %0b actual %0b", $time, exp_w.found, found_o);
          errors++;
        end
        if (last_o !== exp_w.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_w.last, last_o);
          errors++;
        end
      end
      out_wait = no_idle ? 0 : $urandom_range(0, 17);
    end else begin
      if (out_valid_o && out_wait > 0) out_wait--;
      if (in_valid_i && !in_stall_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
    out_stall_i <= (out_wait != 0);
    if (quiet_cycles > 30000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 64; i++) begin
      heur_mem[i] = '0;
      adj_mem[i] = '0;
    end
    nodes_in_use = NODE_COUNT_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_node_count();
    test_long_path();
    test_random(10, 20);
    test_random(64, 15);
    test_random(5, 8);
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
hdl/gbfs_pkg.sv
hdl/gbfs_ctrl.sv
hdl/gbfs_dp.sv
hdl/greedy_best_first_search.sv
tb/sv/greedy_best_first_search_test.sv
